### design/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Types, codes and keyword tables shared by the request head parser.
// ----------------------------------------------------------------------------
package hrhp_pkg;

	localparam int BODY_W = 24;
	localparam int WIDE_W = 32;

	localparam logic [1:0] PH_REQ  = 2'd0;
	localparam logic [1:0] PH_HDR  = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	localparam logic [2:0] ST_NAME     = 3'd0;
	localparam logic [2:0] ST_CONN_WS  = 3'd1;
	localparam logic [2:0] ST_CONN_VAL = 3'd2;
	localparam logic [2:0] ST_LEN_WS   = 3'd3;
	localparam logic [2:0] ST_LEN_DIG  = 3'd4;
	localparam logic [2:0] ST_SKIP     = 3'd5;
	localparam logic [2:0] ST_CONN_BAD = 3'd6;
	localparam logic [2:0] ST_LEN_NEG  = 3'd7;

	localparam logic [2:0] RQ_METHOD  = 3'd0;
	localparam logic [2:0] RQ_URL     = 3'd1;
	localparam logic [2:0] RQ_VERSION = 3'd2;
	localparam logic [2:0] RQ_FAIL    = 3'd7;

	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// keywords, lower case, left-justified in 16 characters
	localparam logic [127:0] KW_GET  = {"get", {13{8'h00}}};
	localparam logic [127:0] KW_VER  = {"http/1.1", {8{8'h00}}};
	localparam logic [127:0] KW_KEEP = {"keep-alive", {6{8'h00}}};
	localparam logic [127:0] KW_CONN = {"connection:", {5{8'h00}}};
	localparam logic [127:0] KW_CLEN = {"content-length:", 8'h00};
	localparam logic [127:0] KW_HOST = {"host:", {11{8'h00}}};

	localparam logic [4:0] LEN_GET  = 5'd3;
	localparam logic [4:0] LEN_VER  = 5'd8;
	localparam logic [4:0] LEN_KEEP = 5'd10;
	localparam logic [4:0] LEN_CONN = 5'd11;
	localparam logic [4:0] LEN_CLEN = 5'd15;
	localparam logic [4:0] LEN_HOST = 5'd5;

	typedef struct packed {
		logic [1:0] phase;
		logic [2:0] field_step;
		logic [4:0] match_pos;
		logic [2:0] match_alive;
		logic       cr_pending;
		logic       line_empty;
		logic       linger_flag;
	} ctl_t;

	localparam ctl_t CTL_INIT = '{
		phase:       PH_REQ,
		field_step:  3'd0,
		match_pos:   5'd0,
		match_alive: 3'b111,
		cr_pending:  1'b0,
		line_empty:  1'b1,
		linger_flag: 1'b0
	};

	function automatic logic [7:0] to_lower(logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= 8'h41 && c <= 8'h5a) begin
			r = c + 8'd32;
		end
		return r;
	endfunction

	function automatic logic kw_hit(logic [127:0] kw, logic [4:0] len, logic [4:0] pos,
			logic [7:0] lc);
		logic [3:0] p;
		p = pos[3:0];
		return (pos < len) && (lc == kw[{~p, 3'b111} -: 8]);
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

### design/hrhp_step.sv
// ----------------------------------------------------------------------------
// hrhp_step
// Next-state logic of the parser for one accepted byte.
// ----------------------------------------------------------------------------
module hrhp_step
	import hrhp_pkg::*;
#(
	parameter int LENGTH_BITS = 24
) (
	input  ctl_t                   ctl,
	input  logic [LENGTH_BITS-1:0] length_value,
	input  logic [LENGTH_BITS-1:0] body_left,
	input  logic [7:0]             data_byte,
	output ctl_t                   ctl_d,
	output logic [LENGTH_BITS-1:0] length_d,
	output logic [LENGTH_BITS-1:0] left_d,
	output logic                   emit,
	output logic                   bad
);

	logic [7:0]             lc;
	logic [3:0]             digit;
	logic [LENGTH_BITS+3:0] prod;
	logic [LENGTH_BITS-1:0] left_dec;
	logic [2:0]             alive_n;
	logic [4:0]             pos_n;
	logic [4:0]             keep_pos;

	assign lc    = to_lower(data_byte);
	assign digit = data_byte[3:0];
	assign prod  = ({4'd0, length_value} << 3) + ({4'd0, length_value} << 1)
		+ (LENGTH_BITS+4)'(digit);
	assign left_dec = (body_left != '0) ? body_left - 1'b1 : '0;
	assign pos_n    = ctl.match_pos + 5'd1;
	assign keep_pos = (ctl.field_step == ST_CONN_WS) ? 5'd0 : ctl.match_pos;

	always_comb begin
		alive_n[0] = ctl.match_alive[0] && kw_hit(KW_CONN, LEN_CONN, ctl.match_pos, lc);
		alive_n[1] = ctl.match_alive[1] && kw_hit(KW_CLEN, LEN_CLEN, ctl.match_pos, lc);
		alive_n[2] = ctl.match_alive[2] && kw_hit(KW_HOST, LEN_HOST, ctl.match_pos, lc);
	end

	always_comb begin
		ctl_d    = ctl;
		length_d = length_value;
		left_d   = body_left;
		emit     = 1'b0;
		bad      = 1'b0;
		if (ctl.phase == PH_BODY) begin
			left_d = left_dec;
			emit   = (left_dec == '0);
		end else begin
			ctl_d.phase = (ctl.phase == PH_HDR) ? PH_HDR : PH_REQ;
			if (ctl.cr_pending) begin
				if (data_byte != CH_LF) begin
					emit = 1'b1;
					bad  = 1'b1;
				end else if (ctl_d.phase == PH_REQ) begin
					if (ctl.field_step == RQ_VERSION && ctl.match_pos == LEN_VER) begin
						ctl_d       = CTL_INIT;
						ctl_d.phase = PH_HDR;
						ctl_d.linger_flag = ctl.linger_flag;
					end else begin
						emit = 1'b1;
						bad  = 1'b1;
					end
				end else if (ctl.line_empty) begin
					if (length_value == '0) begin
						emit = 1'b1;
					end else begin
						ctl_d       = CTL_INIT;
						ctl_d.phase = PH_BODY;
						ctl_d.linger_flag = ctl.linger_flag;
						left_d      = length_value;
					end
				end else begin
					ctl_d       = CTL_INIT;
					ctl_d.phase = PH_HDR;
					ctl_d.linger_flag = ctl.linger_flag;
					if (ctl.field_step == ST_CONN_WS || ctl.field_step == ST_CONN_VAL ||
							ctl.field_step == ST_CONN_BAD) begin
						ctl_d.linger_flag = (ctl.field_step == ST_CONN_VAL) &&
							(ctl.match_pos == LEN_KEEP);
					end
				end
			end else if (data_byte == CH_CR) begin
				ctl_d.cr_pending = 1'b1;
			end else if (data_byte == CH_LF) begin
				emit = 1'b1;
				bad  = 1'b1;
			end else if (ctl_d.phase == PH_REQ) begin
				ctl_d.line_empty = 1'b0;
				unique case (ctl.field_step)
					RQ_METHOD: begin
						if (is_blank(data_byte)) begin
							ctl_d.field_step = (ctl.match_pos == LEN_GET) ? RQ_URL : RQ_FAIL;
						end else if (kw_hit(KW_GET, LEN_GET, ctl.match_pos, lc)) begin
							ctl_d.match_pos = pos_n;
						end else begin
							ctl_d.field_step = RQ_FAIL;
						end
					end
					RQ_URL: begin
						if (is_blank(data_byte)) begin
							ctl_d.field_step = RQ_VERSION;
							ctl_d.match_pos  = 5'd0;
						end
					end
					RQ_VERSION: begin
						if (kw_hit(KW_VER, LEN_VER, ctl.match_pos, lc)) begin
							ctl_d.match_pos = pos_n;
						end else begin
							ctl_d.field_step = RQ_FAIL;
						end
					end
					default: begin
						ctl_d.field_step = RQ_FAIL;
					end
				endcase
			end else begin
				ctl_d.line_empty = 1'b0;
				unique case (ctl.field_step)
					ST_NAME: begin
						ctl_d.match_alive = alive_n;
						ctl_d.match_pos   = pos_n;
						priority if (alive_n[0] && pos_n == LEN_CONN) begin
							ctl_d.field_step = ST_CONN_WS;
						end else if (alive_n[1] && pos_n == LEN_CLEN) begin
							ctl_d.field_step = ST_LEN_WS;
							length_d         = '0;
						end else if (alive_n[2] && pos_n == LEN_HOST) begin
							ctl_d.field_step = ST_SKIP;
						end else if (alive_n == 3'b000) begin
							ctl_d.field_step = ST_SKIP;
						end else begin
							ctl_d.field_step = ST_NAME;
						end
					end
					ST_CONN_WS, ST_CONN_VAL: begin
						if (ctl.field_step == ST_CONN_VAL || !is_blank(data_byte)) begin
							ctl_d.field_step = ST_CONN_VAL;
							if (kw_hit(KW_KEEP, LEN_KEEP, keep_pos, lc)) begin
								ctl_d.match_pos = keep_pos + 5'd1;
							end else begin
								ctl_d.match_pos  = keep_pos;
								ctl_d.field_step = ST_CONN_BAD;
							end
						end
					end
					ST_LEN_WS: begin
						priority if (is_blank(data_byte) || data_byte == CH_VT ||
								data_byte == CH_FF) begin
							ctl_d.field_step = ST_LEN_WS;
						end else if (data_byte == CH_PLUS) begin
							ctl_d.field_step = ST_LEN_DIG;
						end else if (data_byte == CH_MINUS) begin
							ctl_d.field_step = ST_LEN_NEG;
						end else if (is_digit(data_byte)) begin
							ctl_d.field_step = ST_LEN_DIG;
							length_d         = LENGTH_BITS'(digit);
						end else begin
							ctl_d.field_step = ST_SKIP;
						end
					end
					ST_LEN_DIG: begin
						if (is_digit(data_byte)) begin
							length_d = (prod[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ?
								'1 : prod[LENGTH_BITS-1:0];
						end else begin
							ctl_d.field_step = ST_SKIP;
						end
					end
					ST_LEN_NEG: begin
						if (!is_digit(data_byte)) begin
							ctl_d.field_step = ST_SKIP;
						end
					end
					default: begin
						ctl_d.field_step = ctl.field_step;
					end
				endcase
			end
		end
	end

endmodule

### design/http_request_head_parser.sv
// ----------------------------------------------------------------------------
// http_request_head_parser
// Byte-wide HTTP/1.1 GET request head parser with body byte counting.
// ----------------------------------------------------------------------------
// Takes one request byte per cycle on the req channel and gives one verdict
// per request on the res channel: complete (verdict 0, with the keep-alive flag
// and the saturated Content-Length) or bad (verdict 1, other fields zero). A
// byte is taken every cycle but for a stall; the parser state is updated in the
// cycle of the transaction and the verdict is held in a single output register,
// so the request side stalls only while a verdict waits and res_ready is low.
// After each verdict the parser starts over on the next request.
module http_request_head_parser
	import hrhp_pkg::*;
#(
	parameter int LENGTH_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [7:0]        data_byte,
	output logic              res_valid,
	input  logic              res_ready,
	output logic              verdict,
	output logic              keep_alive,
	output logic [BODY_W-1:0] body_length
);

	ctl_t                   ctl_q;
	ctl_t                   ctl_d;
	logic [LENGTH_BITS-1:0] length_q;
	logic [LENGTH_BITS-1:0] length_d;
	logic [LENGTH_BITS-1:0] left_q;
	logic [LENGTH_BITS-1:0] left_d;
	logic                   emit;
	logic                   bad;
	logic                   fire;
	logic                   res_valid_q;
	logic                   verdict_q;
	logic                   keep_alive_q;
	logic [BODY_W-1:0]      body_length_q;
	logic [WIDE_W-1:0]      length_wide;

	assign req_ready   = !res_valid_q || res_ready;
	assign fire        = req_valid && req_ready;
	assign length_wide = WIDE_W'(length_q);

	hrhp_step #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_step (
		.ctl          (ctl_q),
		.length_value (length_q),
		.body_left    (left_q),
		.data_byte    (data_byte),
		.ctl_d        (ctl_d),
		.length_d     (length_d),
		.left_d       (left_d),
		.emit         (emit),
		.bad          (bad)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= CTL_INIT;
			length_q <= '0;
			left_q   <= '0;
		end else if (fire) begin
			if (emit) begin
				ctl_q    <= CTL_INIT;
				length_q <= '0;
				left_q   <= '0;
			end else begin
				ctl_q    <= ctl_d;
				length_q <= length_d;
				left_q   <= left_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire && emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			verdict_q     <= bad;
			keep_alive_q  <= !bad && ctl_q.linger_flag;
			body_length_q <= bad ? '0 : length_wide[BODY_W-1:0];
		end
	end

	assign res_valid   = res_valid_q;
	assign verdict     = verdict_q;
	assign keep_alive  = keep_alive_q;
	assign body_length = body_length_q;

`ifndef SYNTHESIS
	a_bad_clears_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && verdict |-> !keep_alive && body_length == '0)
		else $error("bad verdict carries nonzero fields");

	a_restart_after_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |=> ctl_q.phase == PH_REQ && ctl_q.line_empty && length_q == '0)
		else $error("parser did not restart after verdict");

	a_body_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.phase == PH_BODY |-> left_q != '0 && !ctl_q.cr_pending)
		else $error("body phase with nothing left to count");

	a_match_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.match_pos <= LEN_CLEN)
		else $error("match position out of range");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !req_ready)
		else $error("transaction accepted while verdict is stalled");
`endif

endmodule
